/* sv/bsrm_pkg.sv */
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared constants, codes and types of the bank switched RAM mapper.
// ----------------------------------------------------------------------------
package bsrm_pkg;

   // RAM geometry
   localparam int RAM_BANKS   = 32;
   localparam int BANK_BYTES  = 8192;
   localparam int OFFSET_W    = $clog2(BANK_BYTES);
   localparam int BANK_W      = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
   localparam int RAM_DEPTH   = RAM_BANKS * BANK_BYTES;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);

   // Bus windows
   localparam int WINDOWS     = 4;
   localparam int WIN_W       = $clog2(WINDOWS);

   // Field widths
   localparam int KIND_W       = 2;
   localparam int ADDR_W       = 16;
   localparam int DATA_W       = 8;
   localparam int BANK_COUNT_W = 6;

   localparam logic [BANK_COUNT_W-1:0] BANK_COUNT_RESET = 6'd32;
   localparam logic [DATA_W-1:0]       BYTE_ONES        = 8'hFF;
   localparam logic [DATA_W-1:0]       BYTE_ZERO        = 8'h00;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Remainder unit: digits resolved per cycle
   localparam int MOD_DIGITS  = 4;
   localparam int MOD_STEPS   = DATA_W / MOD_DIGITS;
   localparam int MOD_STEP_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   // Bus access kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_MEM_READ  = 2'd0,
      KIND_MEM_WRITE = 2'd1,
      KIND_IO_READ   = 2'd2,
      KIND_IO_WRITE  = 2'd3
   } kind_type;

   // Classified operations
   typedef enum logic [2:0] {
      OP_MEM_READ,
      OP_RAM_STORE,
      OP_BANK_SWITCH,
      OP_IO_READ,
      OP_IO_WRITE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [WIN_W-1:0]    window;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   data;
   } cmd_type;

   typedef enum logic [1:0] {
      BE_CLEAR,
      BE_IDLE,
      BE_READ,
      BE_MOD
   } be_state_type;

   typedef struct packed {
      logic clearing;
   } be_status_type;

endpackage

/* sv/bsrm_if.sv */
// ----------------------------------------------------------------------------
// bsrm_if
// Valid/ready channels of the mapper: bus requests, responses, register write.
// ----------------------------------------------------------------------------
interface bsrm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output kind, output address, output data, input ready);
   modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

interface bsrm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

interface bsrm_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/bsrm_ram.sv */
// ----------------------------------------------------------------------------
// bsrm_ram
// Generic single port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one word per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/bsrm_front.sv */
// ----------------------------------------------------------------------------
// bsrm_front
// Accepts bus beats, tracks the write mode bit and classifies each access.
// ----------------------------------------------------------------------------
module bsrm_front import bsrm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bsrm_req_if.sink      req_bus,
   input  be_status_type be_status,
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   logic write_mode_ff;
   logic write_mode_in;
   logic accept;

   // Take a beat when the queue has room and the RAM sweep is over
   assign req_bus.ready = !q_full && !be_status.clearing;
   assign accept        = req_bus.valid && req_bus.ready;
   assign q_push        = accept;

   // Classify the access and update the mode bit
   always_comb begin
      write_mode_in = write_mode_ff;
      q_cmd.window  = req_bus.address[OFFSET_W+WIN_W-1:OFFSET_W];
      q_cmd.offset  = req_bus.address[OFFSET_W-1:0];
      q_cmd.data    = req_bus.data;
      q_cmd.op      = OP_IO_WRITE;
      case (kind_type'(req_bus.kind))
         KIND_MEM_READ: begin
            q_cmd.op = OP_MEM_READ;
         end
         KIND_MEM_WRITE: begin
            q_cmd.op = write_mode_ff ? OP_RAM_STORE : OP_BANK_SWITCH;
         end
         KIND_IO_READ: begin
            q_cmd.op = OP_IO_READ;
            if (accept) begin
               write_mode_in = 1'b1;
            end
         end
         KIND_IO_WRITE: begin
            q_cmd.op = OP_IO_WRITE;
            if (accept) begin
               write_mode_in = 1'b0;
            end
         end
         default: begin
            q_cmd.op = OP_IO_WRITE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_mode_ff <= 1'b0;
      end else begin
         write_mode_ff <= write_mode_in;
      end
   end

endmodule

/* sv/bsrm_queue.sv */
// ----------------------------------------------------------------------------
// bsrm_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bsrm_queue import bsrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff;
   logic [QUEUE_AW:0]     count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/bsrm_back.sv */
// ----------------------------------------------------------------------------
// bsrm_back
// Executes classified commands: RAM access, bank registers, remainder unit,
// response register, and the RAM fill sweep after reset.
// ----------------------------------------------------------------------------
module bsrm_back import bsrm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [BANK_COUNT_W-1:0] csr_data,
   input  logic                    q_empty,
   input  cmd_type                 q_head,
   output logic                    q_pop,
   output be_status_type           be_status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DATA_W-1:0]       rsp_read_data
);

   be_state_type state_ff;
   be_state_type state_in;

   logic [BANK_COUNT_W-1:0] bank_count_ff;
   logic [BANK_COUNT_W-1:0] eff_banks;
   logic [BANK_W-1:0]       bank_sel_ff [WINDOWS];

   logic [RAM_AW-1:0] clear_ptr_ff;
   logic              clear_last;

   logic [BANK_COUNT_W-1:0] mod_rem_ff;
   logic [BANK_COUNT_W-1:0] mod_rem_t;
   logic [DATA_W-1:0]       mod_quo_ff;
   logic [DATA_W-1:0]       mod_quo_t;
   logic [BANK_COUNT_W-1:0] mod_div_ff;
   logic [WIN_W-1:0]        mod_win_ff;
   logic [MOD_STEP_W-1:0]   mod_step_ff;
   logic                    mod_last;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_free;
   logic              rsp_load;
   logic [DATA_W-1:0] rsp_load_data;

   logic              ram_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   logic issue;
   logic mod_start;

   assign be_status.clearing = (state_ff == BE_CLEAR);
   assign clear_last         = (clear_ptr_ff == RAM_AW'(RAM_DEPTH-1));
   assign mod_last           = (mod_step_ff == MOD_STEP_W'(MOD_STEPS-1));
   assign rsp_free           = !rsp_valid_ff || rsp_ready;
   assign issue              = (state_ff == BE_IDLE) && !q_empty && rsp_free;
   assign q_pop              = issue;

   // Clamp the bank count into 1..RAM_BANKS
   always_comb begin
      eff_banks = bank_count_ff;
      if (bank_count_ff == '0) begin
         eff_banks = BANK_COUNT_W'(1);
      end else if (32'(bank_count_ff) > RAM_BANKS) begin
         eff_banks = BANK_COUNT_W'(RAM_BANKS);
      end
   end

   // Resolve MOD_DIGITS remainder digits per cycle
   always_comb begin
      logic [BANK_COUNT_W:0] trial;
      mod_rem_t = mod_rem_ff;
      mod_quo_t = mod_quo_ff;
      for (int i = 0; i < MOD_DIGITS; i++) begin
         trial     = {mod_rem_t, mod_quo_t[DATA_W-1]};
         mod_quo_t = {mod_quo_t[DATA_W-2:0], 1'b0};
         if (trial >= {1'b0, mod_div_ff}) begin
            mod_rem_t = BANK_COUNT_W'(trial - {1'b0, mod_div_ff});
         end else begin
            mod_rem_t = trial[BANK_COUNT_W-1:0];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_CLEAR: begin
            if (clear_last) begin
               state_in = BE_IDLE;
            end
         end
         BE_IDLE: begin
            if (issue && q_head.op == OP_MEM_READ) begin
               state_in = BE_READ;
            end else if (issue && q_head.op == OP_BANK_SWITCH) begin
               state_in = BE_MOD;
            end
         end
         BE_READ: begin
            state_in = BE_IDLE;
         end
         BE_MOD: begin
            if (mod_last) begin
               state_in = BE_IDLE;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   // State outputs: RAM port, response load, remainder start
   always_comb begin
      ram_we        = 1'b0;
      ram_addr      = RAM_AW'({bank_sel_ff[q_head.window], q_head.offset});
      ram_wdata     = q_head.data;
      rsp_load      = 1'b0;
      rsp_load_data = BYTE_ZERO;
      mod_start     = 1'b0;
      case (state_ff)
         BE_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clear_ptr_ff;
            ram_wdata = BYTE_ONES;
         end
         BE_IDLE: begin
            if (issue) begin
               case (q_head.op)
                  OP_MEM_READ: begin
                     rsp_load = 1'b0;
                  end
                  OP_RAM_STORE: begin
                     ram_we   = 1'b1;
                     rsp_load = 1'b1;
                  end
                  OP_BANK_SWITCH: begin
                     mod_start = 1'b1;
                     rsp_load  = 1'b1;
                  end
                  OP_IO_READ: begin
                     rsp_load      = 1'b1;
                     rsp_load_data = BYTE_ONES;
                  end
                  OP_IO_WRITE: begin
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         BE_READ: begin
            rsp_load      = 1'b1;
            rsp_load_data = ram_rdata;
         end
         BE_MOD: begin
            rsp_load = 1'b0;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BE_CLEAR;
         clear_ptr_ff  <= '0;
         bank_count_ff <= BANK_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         mod_step_ff   <= '0;
         for (int w = 0; w < WINDOWS; w++) begin
            bank_sel_ff[w] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == BE_CLEAR) begin
            clear_ptr_ff <= clear_ptr_ff + 1'b1;
         end
         if (csr_write) begin
            bank_count_ff <= csr_data;
         end
         if (mod_start) begin
            mod_step_ff <= '0;
         end else if (state_ff == BE_MOD) begin
            mod_step_ff <= mod_step_ff + 1'b1;
         end
         if (state_ff == BE_MOD && mod_last) begin
            bank_sel_ff[mod_win_ff] <= BANK_W'(mod_rem_t);
         end
      end
   end

   // Remainder operands and response payload
   always_ff @(posedge clock) begin
      if (mod_start) begin
         mod_rem_ff <= '0;
         mod_quo_ff <= q_head.data;
         mod_div_ff <= eff_banks;
         mod_win_ff <= q_head.window;
      end else if (state_ff == BE_MOD) begin
         mod_rem_ff <= mod_rem_t;
         mod_quo_ff <= mod_quo_t;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_load_data;
      end
   end

   bsrm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // Checks
   a_pop_needs_free_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid_ff || rsp_ready))
      else $error("command issued while response register is occupied");

   a_read_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_READ) |-> !rsp_valid_ff)
      else $error("read data arrives with response register occupied");

   a_mod_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_MOD && mod_last) |=> (state_ff == BE_IDLE))
      else $error("remainder unit overran its step count");

   a_mod_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_MOD) |-> (mod_rem_ff < mod_div_ff))
      else $error("partial remainder not below divisor");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_CLEAR) |-> (!q_pop && !rsp_valid_ff))
      else $error("activity during RAM fill sweep");

endmodule

/* sv/bank_switched_ram_mapper_unit.sv */
// ----------------------------------------------------------------------------
// bank_switched_ram_mapper_unit
// Bank switched cartridge RAM mapper with four 8 KB windows on a 64 KB bus.
// ----------------------------------------------------------------------------
// After reset the block fills its RAM with 0xFF, one byte per cycle, while
// req_bus.ready stays low; register writes on csr_bus are taken at any time.
// Beats then enter a two-entry command queue and leave the back end one at a
// time: I/O accesses and RAM stores finish at issue, a memory read waits for
// the registered RAM read port, and a bank switch runs the remainder unit,
// which resolves four bits per cycle. I/O accesses, stores and bank switches
// load the response register at issue, memory reads when the RAM data
// returns; every beat gives exactly one response.
// ----------------------------------------------------------------------------
module bank_switched_ram_mapper_unit import bsrm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bsrm_req_if.sink   req_bus,
   bsrm_rsp_if.source rsp_bus,
   bsrm_csr_if.sink   csr_bus
);

   cmd_type       q_cmd;
   cmd_type       q_head;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   be_status_type be_status;

   // Register port never stalls
   assign csr_bus.ready = 1'b1;

   bsrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .be_status (be_status),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   bsrm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   bsrm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_bus.valid),
      .csr_data      (csr_bus.data),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .be_status     (be_status),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_read_data (rsp_bus.read_data)
   );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bank switched RAM mapper. A short table of
// directed bus accesses is followed by randomized phases under several bank
// counts, mostly bank-select / store / read-back bursts with random content.
// Every response beat is checked against a pinned table byte or a local
// mapper model with its own bank registers, write mode flag and RAM image.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bsrm_pkg::*;

   // Directed stimulus row; a set pin_result means want_byte is the result
   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data;
      logic        pin_result;
      logic [7:0]  want_byte;
   } access_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam int PHASE_ITEMS   = 215;
   localparam int PHASES        = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 120;
   localparam int IDLE_PERCENT  = 7;
   localparam int QUIET_PHASE   = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsrm_req_if req_bus ();
   bsrm_rsp_if rsp_bus ();
   bsrm_csr_if csr_bus ();

   bank_switched_ram_mapper_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Mapper model state
   logic [BANK_W-1:0]       window_bank [WINDOWS];
   logic                    store_enable;
   logic [BANK_COUNT_W-1:0] bank_count_reg;
   logic [DATA_W-1:0]       ram_image [RAM_DEPTH];

   logic [DATA_W-1:0] expected_bytes [$];
   int                error_count   = 0;
   int                sent_items    = 0;
   int                rsp_beats     = 0;
   bit                quiet_stretch = 1'b0;

   access_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KIND_MEM_READ,  16'h0000, 8'h00, 1'b1, 8'hFF},
      '{KIND_MEM_READ,  16'hFFFF, 8'hFF, 1'b1, 8'hFF},
      '{KIND_IO_WRITE,  16'hFFFF, 8'hFF, 1'b1, 8'h00},
      '{KIND_MEM_WRITE, 16'h2000, 8'hFF, 1'b1, 8'h00},
      '{KIND_MEM_WRITE, 16'hE000, 8'h00, 1'b1, 8'h00},
      '{KIND_IO_READ,   16'h0000, 8'h00, 1'b1, 8'hFF},
      '{KIND_MEM_WRITE, 16'h2000, 8'h5A, 1'b1, 8'h00},
      '{KIND_MEM_READ,  16'hA000, 8'h00, 1'b0, 8'h00},
      '{KIND_MEM_WRITE, 16'h3FFF, 8'hA5, 1'b1, 8'h00},
      '{KIND_MEM_READ,  16'hBFFF, 8'h00, 1'b0, 8'h00},
      '{KIND_MEM_WRITE, 16'h0000, 8'h00, 1'b1, 8'h00},
      '{KIND_MEM_READ,  16'h8000, 8'h00, 1'b0, 8'h00},
      '{KIND_IO_WRITE,  16'h1234, 8'h77, 1'b1, 8'h00},
      '{KIND_MEM_WRITE, 16'h4000, 8'h80, 1'b1, 8'h00},
      '{KIND_MEM_WRITE, 16'h5FFF, 8'h41, 1'b1, 8'h00},
      '{KIND_MEM_READ,  16'h4000, 8'h00, 1'b0, 8'h00},
      '{KIND_MEM_WRITE, 16'h2123, 8'h00, 1'b1, 8'h00},
      '{KIND_MEM_READ,  16'h2000, 8'h00, 1'b0, 8'h00},
      '{KIND_IO_READ,   16'hFFFF, 8'hFF, 1'b1, 8'hFF},
      '{KIND_MEM_WRITE, 16'h6000, 8'hFF, 1'b1, 8'h00},
      '{KIND_MEM_READ,  16'h0000, 8'h00, 1'b0, 8'h00},
      '{KIND_IO_WRITE,  16'h0000, 8'h00, 1'b1, 8'h00}
   };

   // Free-running clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one bus access to the model and return the byte it answers with
   function automatic logic [DATA_W-1:0] map_access(kind_type kind, logic [15:0] address,
                                                    logic [DATA_W-1:0] data);
      logic [WIN_W-1:0]  win;
      int unsigned       ram_slot;
      int unsigned       span;
      logic [DATA_W-1:0] answer;
      win      = address[WIN_W+OFFSET_W-1:OFFSET_W];
      ram_slot = window_bank[win] * BANK_BYTES + address[OFFSET_W-1:0];
      answer   = BYTE_ZERO;
      case (kind)
         KIND_MEM_READ: begin
            answer = ram_image[ram_slot];
         end
         KIND_MEM_WRITE: begin
            if (store_enable) begin
               ram_image[ram_slot] = data;
            end else begin
               // clamp the modulus into 1..RAM_BANKS
               span = bank_count_reg;
               if (span == 0) span = 1;
               if (span > RAM_BANKS) span = RAM_BANKS;
               window_bank[win] = BANK_W'(int'(data) % span);
            end
         end
         KIND_IO_READ: begin
            store_enable = 1'b1;
            answer       = BYTE_ONES;
         end
         default: begin
            store_enable = 1'b0;
         end
      endcase
      return answer;
   endfunction

   // Offer one request beat and record its expected response once taken
   task automatic issue_access(kind_type kind, logic [15:0] address, logic [DATA_W-1:0] data,
                               logic pin_result, logic [DATA_W-1:0] want_byte);
      logic [DATA_W-1:0] answer;
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.address <= address;
      req_bus.data    <= data;
      do @(posedge clock); while (!req_bus.ready);
      answer = map_access(kind, address, data);
      expected_bytes.push_back(pin_result ? want_byte : answer);
      sent_items++;
   endtask

   // Drop valid and wait for all outstanding responses, then let the back end settle
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bank_count(logic [BANK_COUNT_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      bank_count_reg = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Bus address in a given window: mostly a few offsets at the window edges
   function automatic logic [15:0] window_address(logic [WIN_W-1:0] win);
      logic [OFFSET_W-1:0] offset;
      if ($urandom_range(0, 9) < 6) begin
         offset = $urandom_range(0, 1) ? OFFSET_W'($urandom_range(0, 7))
                                       : OFFSET_W'(BANK_BYTES - 1 - $urandom_range(0, 7));
      end else begin
         offset = OFFSET_W'($urandom);
      end
      return {1'($urandom), win, offset};
   endfunction

   // Select a bank, enter write mode, store a few bytes, then read them back
   task automatic bank_burst();
      logic [WIN_W-1:0] win;
      logic [15:0]      touched [4];
      int               count;
      win   = WIN_W'($urandom);
      count = $urandom_range(1, 4);
      issue_access(KIND_IO_WRITE, 16'($urandom), 8'($urandom), 1'b0, BYTE_ZERO);
      issue_access(KIND_MEM_WRITE, window_address(win), 8'($urandom), 1'b0, BYTE_ZERO);
      issue_access(KIND_IO_READ, 16'($urandom), 8'($urandom), 1'b0, BYTE_ZERO);
      for (int i = 0; i < count; i++) begin
         touched[i] = window_address(win);
         issue_access(KIND_MEM_WRITE, touched[i], 8'($urandom), 1'b0, BYTE_ZERO);
      end
      for (int i = 0; i < count; i++) begin
         issue_access(KIND_MEM_READ, touched[i], BYTE_ZERO, 1'b0, BYTE_ZERO);
      end
   endtask

   // Single access: biased toward the hot offsets, sometimes fully random
   task automatic stray_access();
      kind_type    kind;
      logic [15:0] address;
      kind    = kind_type'($urandom_range(0, 3));
      address = $urandom_range(0, 1) ? window_address(WIN_W'($urandom)) : 16'($urandom);
      issue_access(kind, address, 8'($urandom), 1'b0, BYTE_ZERO);
   endtask

   // Response side: random idling plus long hold-offs that back up the request side
   initial begin
      int hold_left;
      int hold_mark;
      hold_left     = 0;
      hold_mark     = 400;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (rsp_beats >= hold_mark) begin
            rsp_bus.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_mark = (hold_mark < 1300) ? 1300 : 32'h7FFF_FFFF;
         end else begin
            rsp_bus.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_beats++;
         if (expected_bytes.size() == 0) begin
            $error("read_data beat %0h arrived with no access outstanding", rsp_bus.read_data);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.read_data !== want) begin
               $error("read_data mismatch: expected %02h, actual %02h", want,
                      rsp_bus.read_data);
               error_count++;
            end
         end
      end
   end

   // Hard stop well past the slowest legal run, RAM clearing sweep included
   initial begin
      #30_000_000;
      $display("bank_switched_ram_mapper_unit test failed");
      $finish;
   end

   // Main sequence
   initial begin
      int bank_settings [PHASES];
      int target;
      bank_settings = '{0, 1, 63, 32, 5, 33, 2, 17};
      bank_settings[PHASES-1] = $urandom_range(1, 63);
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_MEM_READ;
      req_bus.address = 16'h0000;
      req_bus.data    = BYTE_ZERO;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = BANK_COUNT_RESET;

      // Model reset state
      for (int w = 0; w < WINDOWS; w++) window_bank[w] = '0;
      for (int i = 0; i < RAM_DEPTH; i++) ram_image[i] = BYTE_ONES;
      store_enable   = 1'b0;
      bank_count_reg = BANK_COUNT_RESET;

      // Hold reset, then release it on a falling clock edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_bank_count(6'd32);

      // Walk the directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         issue_access(directed_rows[r].kind, directed_rows[r].address, directed_rows[r].data,
                      directed_rows[r].pin_result, directed_rows[r].want_byte);
      end
      drain_responses();

      // Random phases, one bank count each
      for (int p = 0; p < PHASES; p++) begin
         write_bank_count(BANK_COUNT_W'(bank_settings[p]));
         quiet_stretch = (p == QUIET_PHASE);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            if ($urandom_range(0, 9) < 6) bank_burst();
            else stray_access();
         end
         drain_responses();
         quiet_stretch = 1'b0;
      end

      if (error_count == 0) begin
         $display("bank_switched_ram_mapper_unit test passed");
      end else begin
         $display("bank_switched_ram_mapper_unit test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/bsrm_pkg.sv
sv/bsrm_if.sv
sv/bsrm_ram.sv
sv/bsrm_front.sv
sv/bsrm_queue.sv
sv/bsrm_back.sv
sv/bank_switched_ram_mapper_unit.sv
sim/testbench.sv
